// File: rtl/text_console_cell_buffer_assert.svh
// Assertion macros used by the text console cell buffer sequencer.
`ifndef TEXT_CONSOLE_CELL_BUFFER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tcc_pkg.sv
// Shared constants, types and codes of the text console cell buffer.
package tcc_pkg;

	localparam int MAX_ROWS    = 16;
	localparam int MAX_COLUMNS = 32;
	localparam int CELL_COUNT  = MAX_ROWS * MAX_COLUMNS;
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int ADDR_W      = $clog2(CELL_COUNT);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int CHAR_W      = 8;
	localparam int ROWS_CFG_W  = 5;
	localparam int COLS_CFG_W  = 6;
	localparam int PIX_W       = 8;
	localparam int SEL_W       = 8;
	localparam int REG_IDX_W   = 3;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [ROWS_CFG_W-1:0] rows_cfg_t;
	typedef logic [COLS_CFG_W-1:0] cols_cfg_t;

	typedef enum logic [1:0] {
		ACT_PUT_CHAR   = 2'd0,
		ACT_SET_CURSOR = 2'd1,
		ACT_CLEAR      = 2'd2,
		ACT_READ_CELL  = 2'd3
	} action_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ROWS     = 3'd0,
		REG_COLUMNS  = 3'd1,
		REG_ORIGIN_X = 3'd2,
		REG_ORIGIN_Y = 3'd3,
		REG_STEP_X   = 3'd4,
		REG_STEP_Y   = 3'd5
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_CLEAR,
		ST_SCROLL,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		rows_cfg_t        rows;
		cols_cfg_t        cols;
		logic [PIX_W-1:0] origin_x;
		logic [PIX_W-1:0] origin_y;
		logic [PIX_W-1:0] step_x;
		logic [PIX_W-1:0] step_y;
	} geom_t;

	typedef struct packed {
		action_t           action;
		logic [CHAR_W-1:0] char_code;
		logic [SEL_W-1:0]  column_sel;
		logic [SEL_W-1:0]  row_sel;
	} item_t;

endpackage

// File: rtl/tcc_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module tcc_ram #(
	parameter int DATA_W = 8,
	parameter int ADDR_W = 9
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/tcc_cfg.sv
// Configuration registers and limited grid geometry of the console.
module tcc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tcc_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [tcc_pkg::PIX_W-1:0]       cfg_data,
	output tcc_pkg::geom_t                  geom
);

	tcc_pkg::rows_cfg_t              rows_q;
	tcc_pkg::cols_cfg_t              cols_q;
	logic [tcc_pkg::PIX_W-1:0]       origin_x_q;
	logic [tcc_pkg::PIX_W-1:0]       origin_y_q;
	logic [tcc_pkg::PIX_W-1:0]       step_x_q;
	logic [tcc_pkg::PIX_W-1:0]       step_y_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= tcc_pkg::rows_cfg_t'(tcc_pkg::MAX_ROWS);
			cols_q     <= tcc_pkg::cols_cfg_t'(tcc_pkg::MAX_COLUMNS);
			origin_x_q <= 8'd0;
			origin_y_q <= 8'd0;
			step_x_q   <= 8'd6;
			step_y_q   <= 8'd8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tcc_pkg::REG_ROWS:     rows_q     <= cfg_data[tcc_pkg::ROWS_CFG_W-1:0];
				tcc_pkg::REG_COLUMNS:  cols_q     <= cfg_data[tcc_pkg::COLS_CFG_W-1:0];
				tcc_pkg::REG_ORIGIN_X: origin_x_q <= cfg_data;
				tcc_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_data;
				tcc_pkg::REG_STEP_X:   step_x_q   <= cfg_data;
				tcc_pkg::REG_STEP_Y:   step_y_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A count of zero acts as one and a count above the grid acts as the grid size.
	always_comb begin
		if (rows_q == '0) begin
			geom.rows = tcc_pkg::rows_cfg_t'(1);
		end else if (rows_q > tcc_pkg::rows_cfg_t'(tcc_pkg::MAX_ROWS)) begin
			geom.rows = tcc_pkg::rows_cfg_t'(tcc_pkg::MAX_ROWS);
		end else begin
			geom.rows = rows_q;
		end
		if (cols_q == '0) begin
			geom.cols = tcc_pkg::cols_cfg_t'(1);
		end else if (cols_q > tcc_pkg::cols_cfg_t'(tcc_pkg::MAX_COLUMNS)) begin
			geom.cols = tcc_pkg::cols_cfg_t'(tcc_pkg::MAX_COLUMNS);
		end else begin
			geom.cols = cols_q;
		end
		geom.origin_x = origin_x_q;
		geom.origin_y = origin_y_q;
		geom.step_x   = step_x_q;
		geom.step_y   = step_y_q;
	end

endmodule

// File: rtl/tcc_ctrl.sv
// Sequencer that reads, modifies and writes back the cell memory and keeps the cursor.
`include "text_console_cell_buffer_assert.svh"

module tcc_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  tcc_pkg::item_t                item,
	input  tcc_pkg::geom_t                geom,
	output logic                          ram_we,
	output tcc_pkg::addr_t                ram_waddr,
	output logic [tcc_pkg::CHAR_W-1:0]    ram_wdata,
	output tcc_pkg::addr_t                ram_raddr,
	input  logic [tcc_pkg::CHAR_W-1:0]    ram_rdata,
	output logic                          done,
	output logic [tcc_pkg::CHAR_W-1:0]    cell_char,
	output logic [tcc_pkg::PIX_W-1:0]     pixel_x,
	output logic [tcc_pkg::PIX_W-1:0]     pixel_y,
	output logic [tcc_pkg::COL_W-1:0]     cursor_column,
	output logic [tcc_pkg::ROW_W-1:0]     cursor_row_out,
	output logic                          scrolled
);

	tcc_pkg::state_t               state_q, state_d;
	tcc_pkg::item_t                item_q;
	logic [tcc_pkg::COL_W-1:0]     cur_col_q;
	logic [tcc_pkg::ROW_W-1:0]     cur_row_q;
	tcc_pkg::cnt_t                 cnt_q;
	tcc_pkg::cnt_t                 total_q;
	tcc_pkg::cnt_t                 copy_len_q;
	logic                          wr_v_s1;
	tcc_pkg::addr_t                wr_addr_s1;
	logic                          wr_copy_s1;
	logic                          inb_q;
	logic [tcc_pkg::PIX_W-1:0]     px_q;
	logic [tcc_pkg::PIX_W-1:0]     py_q;
	logic [tcc_pkg::CHAR_W-1:0]    cell_q;
	logic                          scrolled_q;
	logic                          done_q;

	tcc_pkg::cols_cfg_t            cols_m1;
	tcc_pkg::rows_cfg_t            rows_m1;
	logic [tcc_pkg::COL_W-1:0]     cc;
	logic [tcc_pkg::ROW_W-1:0]     cr;
	logic                          is_nl;
	logic                          line_end;
	logic                          at_last_row;
	logic                          scroll_req;
	tcc_pkg::cnt_t                 put_addr;
	tcc_pkg::cnt_t                 sel_addr;
	tcc_pkg::cnt_t                 total;
	tcc_pkg::cnt_t                 scroll_src;
	logic                          inb;
	logic [2*tcc_pkg::SEL_W-1:0]   prod_x;
	logic [2*tcc_pkg::SEL_W-1:0]   prod_y;
	logic [tcc_pkg::COL_W-1:0]     set_col;
	logic [tcc_pkg::ROW_W-1:0]     set_row;
	logic                          sweep_last;
	logic                          scroll_last;
	logic                          emit;

	assign cols_m1 = geom.cols - tcc_pkg::cols_cfg_t'(1);
	assign rows_m1 = geom.rows - tcc_pkg::rows_cfg_t'(1);

	assign cc = ({1'b0, cur_col_q} >= geom.cols) ? cols_m1[tcc_pkg::COL_W-1:0] : cur_col_q;
	assign cr = ({1'b0, cur_row_q} >= geom.rows) ? rows_m1[tcc_pkg::ROW_W-1:0] : cur_row_q;

	assign is_nl       = (item_q.char_code == tcc_pkg::NEWLINE_CODE);
	assign line_end    = is_nl || ({1'b0, cc} == cols_m1);
	assign at_last_row = ({1'b0, cr} == rows_m1);
	assign scroll_req  = line_end && at_last_row;

	assign put_addr = tcc_pkg::cnt_t'(cr) * tcc_pkg::cnt_t'(geom.cols) + tcc_pkg::cnt_t'(cc);
	assign sel_addr = tcc_pkg::cnt_t'(item_q.row_sel[tcc_pkg::ROW_W-1:0])
		* tcc_pkg::cnt_t'(geom.cols)
		+ tcc_pkg::cnt_t'(item_q.column_sel[tcc_pkg::COL_W-1:0]);
	assign total      = tcc_pkg::cnt_t'(geom.rows) * tcc_pkg::cnt_t'(geom.cols);
	assign scroll_src = cnt_q + tcc_pkg::cnt_t'(geom.cols);

	assign inb = (item_q.column_sel < {2'b00, geom.cols})
		&& (item_q.row_sel < {3'b000, geom.rows});
	assign prod_x = item_q.column_sel * geom.step_x;
	assign prod_y = item_q.row_sel * geom.step_y;

	assign set_col = (item_q.column_sel < {2'b00, geom.cols})
		? item_q.column_sel[tcc_pkg::COL_W-1:0] : cols_m1[tcc_pkg::COL_W-1:0];
	assign set_row = (item_q.row_sel < {3'b000, geom.rows})
		? item_q.row_sel[tcc_pkg::ROW_W-1:0] : rows_m1[tcc_pkg::ROW_W-1:0];

	assign sweep_last  = (cnt_q == tcc_pkg::cnt_t'(tcc_pkg::CELL_COUNT - 1));
	assign scroll_last = (cnt_q == total_q - tcc_pkg::cnt_t'(1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			tcc_pkg::ST_INIT: begin
				if (sweep_last) begin
					state_d = tcc_pkg::ST_IDLE;
				end
			end
			tcc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = tcc_pkg::ST_EXEC;
				end
			end
			tcc_pkg::ST_EXEC: begin
				case (item_q.action)
					tcc_pkg::ACT_PUT_CHAR:
						state_d = scroll_req ? tcc_pkg::ST_SCROLL : tcc_pkg::ST_IDLE;
					tcc_pkg::ACT_CLEAR:     state_d = tcc_pkg::ST_CLEAR;
					tcc_pkg::ACT_READ_CELL: state_d = tcc_pkg::ST_READ;
					default:                state_d = tcc_pkg::ST_IDLE;
				endcase
			end
			tcc_pkg::ST_READ:  state_d = tcc_pkg::ST_IDLE;
			tcc_pkg::ST_CLEAR: begin
				if (sweep_last) begin
					state_d = tcc_pkg::ST_IDLE;
				end
			end
			tcc_pkg::ST_SCROLL: begin
				if (scroll_last) begin
					state_d = tcc_pkg::ST_FLUSH;
				end
			end
			tcc_pkg::ST_FLUSH: state_d = tcc_pkg::ST_IDLE;
			default:           state_d = tcc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = (state_q != tcc_pkg::ST_IDLE);
		ram_we    = 1'b0;
		ram_waddr = cnt_q[tcc_pkg::ADDR_W-1:0];
		ram_wdata = '0;
		ram_raddr = sel_addr[tcc_pkg::ADDR_W-1:0];
		emit      = 1'b0;
		case (state_q)
			tcc_pkg::ST_INIT: begin
				ram_we = 1'b1;
			end
			tcc_pkg::ST_EXEC: begin
				if (item_q.action == tcc_pkg::ACT_PUT_CHAR && !is_nl) begin
					ram_we    = 1'b1;
					ram_waddr = put_addr[tcc_pkg::ADDR_W-1:0];
					ram_wdata = item_q.char_code;
				end
				emit = (item_q.action == tcc_pkg::ACT_PUT_CHAR && !scroll_req)
					|| (item_q.action == tcc_pkg::ACT_SET_CURSOR);
			end
			tcc_pkg::ST_READ: begin
				emit = 1'b1;
			end
			tcc_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				emit   = sweep_last;
			end
			tcc_pkg::ST_SCROLL: begin
				ram_raddr = scroll_src[tcc_pkg::ADDR_W-1:0];
			end
			tcc_pkg::ST_FLUSH: begin
				emit = 1'b1;
			end
			default: begin
			end
		endcase
		// Write half of the scroll copy: the row below lands one row up, the bottom row is blanked.
		if (wr_v_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wr_addr_s1;
			ram_wdata = wr_copy_s1 ? ram_rdata : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tcc_pkg::ST_INIT;
			cur_col_q <= '0;
			cur_row_q <= '0;
			cnt_q     <= '0;
			wr_v_s1   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			wr_v_s1 <= (state_q == tcc_pkg::ST_SCROLL);
			case (state_q)
				tcc_pkg::ST_INIT, tcc_pkg::ST_CLEAR, tcc_pkg::ST_SCROLL: begin
					cnt_q <= cnt_q + tcc_pkg::cnt_t'(1);
				end
				tcc_pkg::ST_EXEC: begin
					cnt_q <= '0;
					case (item_q.action)
						tcc_pkg::ACT_PUT_CHAR: begin
							if (line_end) begin
								cur_col_q <= '0;
								cur_row_q <= at_last_row ? cr : cr + 1'b1;
							end else begin
								cur_col_q <= cc + 1'b1;
								cur_row_q <= cr;
							end
						end
						tcc_pkg::ACT_SET_CURSOR: begin
							cur_col_q <= set_col;
							cur_row_q <= set_row;
						end
						tcc_pkg::ACT_CLEAR: begin
							cur_col_q <= '0;
							cur_row_q <= '0;
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tcc_pkg::ST_IDLE && start) begin
			item_q <= item;
		end
		if (state_q == tcc_pkg::ST_EXEC) begin
			total_q    <= total;
			copy_len_q <= total - tcc_pkg::cnt_t'(geom.cols);
			inb_q      <= inb;
			cell_q     <= '0;
			scrolled_q <= (item_q.action == tcc_pkg::ACT_PUT_CHAR) && scroll_req;
			if (item_q.action == tcc_pkg::ACT_READ_CELL) begin
				px_q <= geom.origin_x + prod_x[tcc_pkg::PIX_W-1:0];
				py_q <= geom.origin_y + prod_y[tcc_pkg::PIX_W-1:0];
			end else begin
				px_q <= '0;
				py_q <= '0;
			end
		end
		if (state_q == tcc_pkg::ST_READ) begin
			cell_q <= inb_q ? ram_rdata : '0;
		end
		wr_addr_s1 <= cnt_q[tcc_pkg::ADDR_W-1:0];
		wr_copy_s1 <= (cnt_q < copy_len_q);
	end

	assign done           = done_q;
	assign cell_char      = cell_q;
	assign pixel_x        = px_q;
	assign pixel_y        = py_q;
	assign cursor_column  = cur_col_q;
	assign cursor_row_out = cur_row_q;
	assign scrolled       = scrolled_q;

	`TCC_ASSERT_NEXT(a_accept_exec, start && !busy, state_q == tcc_pkg::ST_EXEC,
		"accepted item did not enter execution")
	`TCC_ASSERT_SAME(a_done_idle, done_q, state_q == tcc_pkg::ST_IDLE,
		"result strobe while the sequencer is still busy")
	`TCC_ASSERT_NEXT(a_done_single, done_q, !done_q,
		"two result strobes in consecutive cycles")
	`TCC_ASSERT_SAME(a_scroll_no_overlap, state_q == tcc_pkg::ST_SCROLL && wr_v_s1,
		ram_raddr != wr_addr_s1, "scroll read hits the entry being written back")

endmodule

// File: rtl/text_console_cell_buffer.sv
// Top level of the text console cell buffer.
// Usage: an item (action, char_code, column_sel, row_sel) is taken at a rising edge where
// start is high and busy is low. Each item gives one result, shown on the result ports
// for exactly one cycle while done is high; the receiver cannot stall it.
// Registers are written on the cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data);
// the user must write them only while the block is idle; the block itself does not enforce
// it. cfg_ready is always high and unknown indexes are ignored. put_char without scrolling
// and set_cursor pass through the execute state, read_cell through the execute and read
// states, and done is registered from the last of them; a new item is taken only in idle.
// A put_char that scrolls copies the cell memory one cell per cycle through its single
// read and single write port and ends in the flush state. clear sweeps all 512 cells,
// one per cycle. After reset the block zeroes all 512 cells of the cell memory with busy
// high; configuration writes are taken during that time.
module text_console_cell_buffer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    action,
	input  logic [tcc_pkg::CHAR_W-1:0]    char_code,
	input  logic [tcc_pkg::SEL_W-1:0]     column_sel,
	input  logic [tcc_pkg::SEL_W-1:0]     row_sel,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tcc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [tcc_pkg::PIX_W-1:0]     cfg_data,
	output logic                          done,
	output logic [tcc_pkg::CHAR_W-1:0]    cell_char,
	output logic [tcc_pkg::PIX_W-1:0]     pixel_x,
	output logic [tcc_pkg::PIX_W-1:0]     pixel_y,
	output logic [tcc_pkg::COL_W-1:0]     cursor_column,
	output logic [tcc_pkg::ROW_W-1:0]     cursor_row_out,
	output logic                          scrolled
);

	tcc_pkg::geom_t                geom;
	tcc_pkg::item_t                item;
	logic                          ram_we;
	tcc_pkg::addr_t                ram_waddr;
	logic [tcc_pkg::CHAR_W-1:0]    ram_wdata;
	tcc_pkg::addr_t                ram_raddr;
	logic [tcc_pkg::CHAR_W-1:0]    ram_rdata;

	assign item.action     = tcc_pkg::action_t'(action);
	assign item.char_code  = char_code;
	assign item.column_sel = column_sel;
	assign item.row_sel    = row_sel;

	tcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	tcc_ram #(
		.DATA_W (tcc_pkg::CHAR_W),
		.ADDR_W (tcc_pkg::ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tcc_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.item           (item),
		.geom           (geom),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata),
		.done           (done),
		.cell_char      (cell_char),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.cursor_column  (cursor_column),
		.cursor_row_out (cursor_row_out),
		.scrolled       (scrolled)
	);

endmodule

// File: verif/tb_text_console_cell_buffer.sv
`timescale 1ns / 100ps
// Self-checking testbench for the text console cell buffer with a predictor and a result check.
module tb_text_console_cell_buffer;

	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 600;
	localparam int ITEM_TARGET = 1250;
	localparam int TAIL_OPS = 100;
	localparam logic [tcc_pkg::REG_IDX_W-1:0] LAST_INDEX = (1 << tcc_pkg::REG_IDX_W) - 1;

	typedef enum {OP_ITEM, OP_REG_WRITE, OP_WAIT_IDLE} op_kind_t;

	typedef struct {
		op_kind_t                      kind;
		tcc_pkg::action_t              act;
		logic [tcc_pkg::CHAR_W-1:0]    code;
		logic [tcc_pkg::SEL_W-1:0]     col;
		logic [tcc_pkg::SEL_W-1:0]     row;
		logic [tcc_pkg::REG_IDX_W-1:0] reg_idx;
		logic [tcc_pkg::PIX_W-1:0]     reg_val;
	} console_op_t;

	typedef struct packed {
		logic [tcc_pkg::CHAR_W-1:0] ch;
		logic [tcc_pkg::PIX_W-1:0]  px;
		logic [tcc_pkg::PIX_W-1:0]  py;
		logic [tcc_pkg::COL_W-1:0]  ccol;
		logic [tcc_pkg::ROW_W-1:0]  crow;
		logic                       sc;
	} console_view_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	tcc_pkg::action_t              action = tcc_pkg::ACT_PUT_CHAR;
	logic [tcc_pkg::CHAR_W-1:0]    char_code = '0;
	logic [tcc_pkg::SEL_W-1:0]     column_sel = '0;
	logic [tcc_pkg::SEL_W-1:0]     row_sel = '0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [tcc_pkg::REG_IDX_W-1:0] cfg_index = '0;
	logic [tcc_pkg::PIX_W-1:0]     cfg_data = '0;
	logic                          done;
	logic [tcc_pkg::CHAR_W-1:0]    cell_char;
	logic [tcc_pkg::PIX_W-1:0]     pixel_x;
	logic [tcc_pkg::PIX_W-1:0]     pixel_y;
	logic [tcc_pkg::COL_W-1:0]     cursor_column;
	logic [tcc_pkg::ROW_W-1:0]     cursor_row_out;
	logic                          scrolled;

	console_op_t   pending_ops[$];
	console_view_t expected_views[$];
	logic          item_fire = 1'b0;
	logic          cfg_fire = 1'b0;
	int            gap_left = 0;
	int            mismatch_count = 0;
	int            quiet_cycles = 0;
	int            items_queued = 0;
	int            plan_rows = tcc_pkg::MAX_ROWS;
	int            plan_cols = tcc_pkg::MAX_COLUMNS;

	logic [tcc_pkg::CHAR_W-1:0] grid [tcc_pkg::CELL_COUNT] = '{default: '0};
	int                         cur_col = 0;
	int                         cur_row = 0;
	tcc_pkg::rows_cfg_t         rows_reg = tcc_pkg::MAX_ROWS;
	tcc_pkg::cols_cfg_t         cols_reg = tcc_pkg::MAX_COLUMNS;
	logic [tcc_pkg::PIX_W-1:0]  org_x = 8'd0;
	logic [tcc_pkg::PIX_W-1:0]  org_y = 8'd0;
	logic [tcc_pkg::PIX_W-1:0]  stp_x = 8'd6;
	logic [tcc_pkg::PIX_W-1:0]  stp_y = 8'd8;

	text_console_cell_buffer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.char_code(char_code),
		.column_sel(column_sel),
		.row_sel(row_sel),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.cell_char(cell_char),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.cursor_column(cursor_column),
		.cursor_row_out(cursor_row_out),
		.scrolled(scrolled)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_count(int v, int max);
		if (v == 0)
			return 1;
		if (v > max)
			return max;
		return v;
	endfunction

	function automatic bit line_feed(int rows, int cols);
		cur_col = 0;
		if (cur_row >= rows - 1) begin
			cur_row = rows - 1;
			for (int i = 0; i < (rows - 1) * cols; i++)
				grid[i] = grid[i + cols];
			for (int i = (rows - 1) * cols; i < rows * cols; i++)
				grid[i] = '0;
			return 1'b1;
		end
		cur_row++;
		return 1'b0;
	endfunction

	function automatic console_view_t console_apply(tcc_pkg::action_t act,
			logic [tcc_pkg::CHAR_W-1:0] code, logic [tcc_pkg::SEL_W-1:0] csel,
			logic [tcc_pkg::SEL_W-1:0] rsel);
		console_view_t v;
		int rows;
		int cols;
		v = '0;
		rows = eff_count(rows_reg, tcc_pkg::MAX_ROWS);
		cols = eff_count(cols_reg, tcc_pkg::MAX_COLUMNS);
		case (act)
			tcc_pkg::ACT_PUT_CHAR: begin
				if (cur_col >= cols)
					cur_col = cols - 1;
				if (cur_row >= rows)
					cur_row = rows - 1;
				if (code == tcc_pkg::NEWLINE_CODE) begin
					v.sc = line_feed(rows, cols);
				end else begin
					grid[cur_row * cols + cur_col] = code;
					if (cur_col >= cols - 1)
						v.sc = line_feed(rows, cols);
					else
						cur_col++;
				end
			end
			tcc_pkg::ACT_SET_CURSOR: begin
				cur_col = (csel < cols) ? int'(csel) : cols - 1;
				cur_row = (rsel < rows) ? int'(rsel) : rows - 1;
			end
			tcc_pkg::ACT_CLEAR: begin
				grid = '{default: '0};
				cur_col = 0;
				cur_row = 0;
			end
			default: begin
				if (csel < cols && rsel < rows)
					v.ch = grid[rsel * cols + csel];
				v.px = org_x + csel * stp_x;
				v.py = org_y + rsel * stp_y;
			end
		endcase
		v.ccol = cur_col[tcc_pkg::COL_W-1:0];
		v.crow = cur_row[tcc_pkg::ROW_W-1:0];
		return v;
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic queue_item(tcc_pkg::action_t act, int code, int col, int row);
		console_op_t op;
		op.kind = OP_ITEM;
		op.act = act;
		op.code = code;
		op.col = col;
		op.row = row;
		op.reg_idx = '0;
		op.reg_val = '0;
		pending_ops.push_back(op);
		items_queued++;
	endtask

	task automatic queue_reg(logic [tcc_pkg::REG_IDX_W-1:0] idx, int val);
		console_op_t op;
		op.kind = OP_REG_WRITE;
		op.act = tcc_pkg::ACT_PUT_CHAR;
		op.code = '0;
		op.col = '0;
		op.row = '0;
		op.reg_idx = idx;
		op.reg_val = val;
		pending_ops.push_back(op);
		if (idx == tcc_pkg::REG_ROWS)
			plan_rows = eff_count(tcc_pkg::rows_cfg_t'(val), tcc_pkg::MAX_ROWS);
		if (idx == tcc_pkg::REG_COLUMNS)
			plan_cols = eff_count(tcc_pkg::cols_cfg_t'(val), tcc_pkg::MAX_COLUMNS);
	endtask

	task automatic queue_wait_idle();
		console_op_t op;
		op.kind = OP_WAIT_IDLE;
		op.act = tcc_pkg::ACT_PUT_CHAR;
		op.code = '0;
		op.col = '0;
		op.row = '0;
		op.reg_idx = '0;
		op.reg_val = '0;
		pending_ops.push_back(op);
	endtask

	function automatic int pick_sel(int count);
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(0, 255);
		return $urandom_range(0, count - 1);
	endfunction

	function automatic int pick_pixel();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	task automatic queue_random_item();
		int pick;
		int code;
		pick = $urandom_range(0, 99);
		code = ($urandom_range(0, 6) == 0) ? int'(tcc_pkg::NEWLINE_CODE) : $urandom_range(0, 255);
		if (pick < 55)
			queue_item(tcc_pkg::ACT_PUT_CHAR, code, $urandom_range(0, 255),
				$urandom_range(0, 255));
		else if (pick < 70)
			queue_item(tcc_pkg::ACT_SET_CURSOR, code, pick_sel(plan_cols), pick_sel(plan_rows));
		else if (pick < 98)
			queue_item(tcc_pkg::ACT_READ_CELL, code, pick_sel(plan_cols), pick_sel(plan_rows));
		else
			queue_item(tcc_pkg::ACT_CLEAR, code, $urandom_range(0, 255), $urandom_range(0, 255));
	endtask

	initial begin
		int phase_items;
		int wait_at;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		queue_item(tcc_pkg::ACT_READ_CELL, 0, 0, 0);
		queue_item(tcc_pkg::ACT_PUT_CHAR, 8'h41, 0, 0);
		queue_item(tcc_pkg::ACT_PUT_CHAR, 8'hFF, 0, 0);
		queue_item(tcc_pkg::ACT_PUT_CHAR, 8'h00, 0, 0);
		queue_item(tcc_pkg::ACT_PUT_CHAR, tcc_pkg::NEWLINE_CODE, 0, 0);
		queue_item(tcc_pkg::ACT_READ_CELL, 0, 1, 0);
		queue_item(tcc_pkg::ACT_SET_CURSOR, 0, tcc_pkg::MAX_COLUMNS - 1, tcc_pkg::MAX_ROWS - 1);
		queue_item(tcc_pkg::ACT_PUT_CHAR, 8'h7E, 0, 0);
		queue_item(tcc_pkg::ACT_READ_CELL, 0, tcc_pkg::MAX_COLUMNS - 1, tcc_pkg::MAX_ROWS - 2);
		queue_item(tcc_pkg::ACT_PUT_CHAR, tcc_pkg::NEWLINE_CODE, 0, 0);
		queue_item(tcc_pkg::ACT_SET_CURSOR, 0, 8'hFF, 8'hFF);
		queue_item(tcc_pkg::ACT_READ_CELL, 0, 8'hFF, 8'hFF);
		queue_wait_idle();
		queue_reg(tcc_pkg::REG_ORIGIN_X, 8'hFF);
		queue_reg(tcc_pkg::REG_ORIGIN_Y, 8'hFF);
		queue_reg(tcc_pkg::REG_STEP_X, 8'hFF);
		queue_reg(tcc_pkg::REG_STEP_Y, 8'hFF);
		queue_item(tcc_pkg::ACT_READ_CELL, 0, 8'hFF, 8'hFF);
		queue_item(tcc_pkg::ACT_READ_CELL, 0, 0, 0);
		// The cursor sits on the last cell of the full grid and must be pulled into the small one.
		queue_reg(tcc_pkg::REG_ROWS, 4);
		queue_reg(tcc_pkg::REG_COLUMNS, 8);
		queue_item(tcc_pkg::ACT_PUT_CHAR, 8'h5A, 0, 0);
		queue_item(tcc_pkg::ACT_READ_CELL, 0, 7, 3);
		queue_item(tcc_pkg::ACT_CLEAR, 0, 0, 0);
		queue_item(tcc_pkg::ACT_READ_CELL, 0, 0, 0);
		queue_reg(tcc_pkg::REG_ROWS, 8'hFF);
		queue_reg(tcc_pkg::REG_COLUMNS, 0);
		queue_item(tcc_pkg::ACT_PUT_CHAR, 8'h61, 0, 0);
		queue_reg(tcc_pkg::REG_ROWS, 0);
		queue_reg(tcc_pkg::REG_COLUMNS, 8'hFF);
		queue_item(tcc_pkg::ACT_PUT_CHAR, 8'h62, 0, 0);
		queue_reg(LAST_INDEX, 8'hA5);
		queue_item(tcc_pkg::ACT_READ_CELL, 0, 1, 0);

		while (items_queued < ITEM_TARGET) begin
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: queue_reg(tcc_pkg::REG_ROWS, 0);
					1: queue_reg(tcc_pkg::REG_ROWS, 1);
					2: queue_reg(tcc_pkg::REG_ROWS, tcc_pkg::MAX_ROWS);
					default: queue_reg(tcc_pkg::REG_ROWS, $urandom_range(0, 255));
				endcase
				case ($urandom_range(0, 3))
					0: queue_reg(tcc_pkg::REG_COLUMNS, 0);
					1: queue_reg(tcc_pkg::REG_COLUMNS, 1);
					2: queue_reg(tcc_pkg::REG_COLUMNS, tcc_pkg::MAX_COLUMNS);
					default: queue_reg(tcc_pkg::REG_COLUMNS, $urandom_range(0, 255));
				endcase
			end else begin
				queue_reg(tcc_pkg::REG_ROWS, $urandom_range(1, 4));
				queue_reg(tcc_pkg::REG_COLUMNS, $urandom_range(1, 8));
			end
			if ($urandom_range(0, 1))
				queue_reg(tcc_pkg::REG_ORIGIN_X, pick_pixel());
			if ($urandom_range(0, 1))
				queue_reg(tcc_pkg::REG_ORIGIN_Y, pick_pixel());
			if ($urandom_range(0, 1))
				queue_reg(tcc_pkg::REG_STEP_X, pick_pixel());
			if ($urandom_range(0, 1))
				queue_reg(tcc_pkg::REG_STEP_Y, pick_pixel());
			if ($urandom_range(0, 5) == 0)
				queue_reg($urandom_range(tcc_pkg::REG_STEP_Y + 1, LAST_INDEX),
					$urandom_range(0, 255));
			phase_items = $urandom_range(15, 50);
			wait_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, phase_items - 1) : -1;
			for (int i = 0; i < phase_items; i++) begin
				if (i == wait_at)
					queue_wait_idle();
				queue_random_item();
			end
		end

		@(posedge clk);
		while (pending_ops.size() > 0 || start || cfg_valid || expected_views.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	always @(negedge clk) begin : driver
		console_op_t op;
		logic next_start;
		logic next_cfg;
		if (arst_n && !((start && !item_fire) || (cfg_valid && !cfg_fire))) begin
			next_start = 1'b0;
			next_cfg = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_ops.size() > 0) begin
				op = pending_ops[0];
				case (op.kind)
					OP_ITEM: begin
						void'(pending_ops.pop_front());
						action <= op.act;
						char_code <= op.code;
						column_sel <= op.col;
						row_sel <= op.row;
						next_start = 1'b1;
						if (pending_ops.size() > TAIL_OPS && $urandom_range(0, 3) == 0)
							gap_left = $urandom_range(1, 3);
					end
					OP_REG_WRITE: begin
						if (expected_views.size() == 0) begin
							void'(pending_ops.pop_front());
							cfg_index <= op.reg_idx;
							cfg_data <= op.reg_val;
							next_cfg = 1'b1;
						end
					end
					default: begin
						if (expected_views.size() == 0)
							void'(pending_ops.pop_front());
					end
				endcase
			end
			start <= next_start;
			cfg_valid <= next_cfg;
		end
	end

	always @(posedge clk) begin : monitor
		console_view_t want;
		item_fire <= start && !busy;
		cfg_fire <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tcc_pkg::REG_ROWS: rows_reg = cfg_data[tcc_pkg::ROWS_CFG_W-1:0];
					tcc_pkg::REG_COLUMNS: cols_reg = cfg_data[tcc_pkg::COLS_CFG_W-1:0];
					tcc_pkg::REG_ORIGIN_X: org_x = cfg_data;
					tcc_pkg::REG_ORIGIN_Y: org_y = cfg_data;
					tcc_pkg::REG_STEP_X: stp_x = cfg_data;
					tcc_pkg::REG_STEP_Y: stp_y = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				expected_views.push_back(console_apply(action, char_code, column_sel, row_sel));
			if (done) begin
				if (expected_views.size() == 0) begin
					$display("%0t: result with no item outstanding", $time);
					mismatch_count++;
				end else begin
					want = expected_views.pop_front();
					check_field("cell_char", want.ch, cell_char);
					check_field("pixel_x", want.px, pixel_x);
					check_field("pixel_y", want.py, pixel_y);
					check_field("cursor_column", want.ccol, cursor_column);
					check_field("cursor_row_out", want.crow, cursor_row_out);
					check_field("scrolled", want.sc, scrolled);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/tcc_pkg.sv
rtl/tcc_ram.sv
rtl/tcc_cfg.sv
rtl/tcc_ctrl.sv
rtl/text_console_cell_buffer.sv
verif/tb_text_console_cell_buffer.sv
